// File: rtl/indexed_binary_heap_queue_top_defines.svh
`ifndef INDEXED_BINARY_HEAP_QUEUE_TOP_DEFINES_SVH
`define INDEXED_BINARY_HEAP_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IBHQ_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IBHQ_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/ibhq_pkg.sv
`timescale 1ns / 1ps
package ibhq_pkg;
    localparam int CAPACITY = 1024;
    localparam int COST_W   = 32;
    localparam int EL_W     = 10;
    localparam int SLOT_W   = 11;
    localparam int HDEPTH   = CAPACITY + 1;

    localparam logic [1:0] ST_NEVER  = 2'd0;
    localparam logic [1:0] ST_QUEUED = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_RESET  = 2'd3;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;
    localparam logic [1:0] STS_DONE  = 2'd3;

    typedef struct packed {
        logic [EL_W-1:0]          elem;
        logic signed [COST_W-1:0] cost;
    } t_hent;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [1:0]        state;
    } t_eent;

    function automatic logic outranks(input logic order,
                                      input logic signed [COST_W-1:0] a,
                                      input logic signed [COST_W-1:0] b);
        outranks = order ? (a > b) : (a < b);
    endfunction
endpackage

// File: rtl/ibhq_ram.sv
`timescale 1ns / 1ps
module ibhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/indexed_binary_heap_queue_top.sv
`timescale 1ns / 1ps
// Update looks up the element, then sifts its entry up one level at a time; remove takes the root
// and sifts the last entry down from it; delete moves the last entry into the freed slot and sifts
// it up or down; reset-all clears the element store.
// One word in flight at a time; a new word is taken once the result is in the output register.
// Throughput is set by the sift loop through the heap-slot memory (one read port).
// Reset (synchronous, active low) runs a clearing pass over all 1024 entries of the element store.
module indexed_binary_heap_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // element[9:0], cost_value[41:10], zero pad
    input  logic [1:0]  i_s_tuser,  // opcode[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,  // top_element[9:0], status[11:10],
                                    // queued_count[22:12], is_empty[23]
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);
    import ibhq_pkg::*;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_UPD    = 4'd2;
    localparam logic [3:0] S_SU_RD  = 4'd3;
    localparam logic [3:0] S_SU_CMP = 4'd4;
    localparam logic [3:0] S_FIN    = 4'd5;
    localparam logic [3:0] S_SD_RL  = 4'd6;
    localparam logic [3:0] S_SD_RR  = 4'd7;
    localparam logic [3:0] S_SD_CMP = 4'd8;
    localparam logic [3:0] S_RM1    = 4'd9;
    localparam logic [3:0] S_RM2    = 4'd10;
    localparam logic [3:0] S_DL1    = 4'd11;
    localparam logic [3:0] S_DL2    = 4'd12;
    localparam logic [3:0] S_DL3    = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    logic [3:0]        r_state, n_state;
    logic              r_init, n_init;
    logic              r_order;
    logic [SLOT_W-1:0] r_last, n_last;
    logic [EL_W-1:0]   r_clr, n_clr;
    logic [SLOT_W-1:0] r_i, n_i;
    logic [EL_W-1:0]   r_e, n_e;
    logic signed [COST_W-1:0] r_c, n_c;
    logic [EL_W-1:0]   r_el, n_el;
    logic signed [COST_W-1:0] r_cost, n_cost;
    logic signed [COST_W-1:0] r_dc, n_dc;
    t_hent             r_lt, n_lt;
    logic              r_hasr, n_hasr;
    logic [EL_W-1:0]   r_top, n_top;
    logic [1:0]        r_sts, n_sts;
    logic              r_ov, n_ov;
    logic [23:0]       r_od, n_od;

    logic              h_we;
    logic [SLOT_W-1:0] h_wa, h_ra;
    t_hent             h_wd, h_rd;
    logic              e_we;
    logic [EL_W-1:0]   e_wa, e_ra;
    t_eent             e_wd, e_rd;

    logic [SLOT_W:0]   w_l;
    logic [SLOT_W-1:0] w_r;
    logic              w_acc;

    ibhq_ram #(.WIDTH($bits(t_hent)), .DEPTH(HDEPTH)) u_hmem (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_raddr(h_ra), .o_rdata(h_rd)
    );

    ibhq_ram #(.WIDTH($bits(t_eent)), .DEPTH(CAPACITY)) u_emem (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_wa), .i_wdata(e_wd),
        .i_raddr(e_ra), .o_rdata(e_rd)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;
    assign w_l        = {r_i, 1'b0};
    assign w_r        = w_l[SLOT_W-1:0] + SLOT_W'(1);

    always_comb begin
        n_state = r_state;
        n_init  = r_init;
        n_last  = r_last;
        n_clr   = r_clr;
        n_i     = r_i;
        n_e     = r_e;
        n_c     = r_c;
        n_el    = r_el;
        n_cost  = r_cost;
        n_dc    = r_dc;
        n_lt    = r_lt;
        n_hasr  = r_hasr;
        n_top   = r_top;
        n_sts   = r_sts;
        n_ov    = r_ov && !i_m_tready;
        n_od    = r_od;
        h_we    = 1'b0;
        h_wa    = r_i;
        h_wd    = '{elem: r_e, cost: r_c};
        h_ra    = SLOT_W'(1);
        e_we    = 1'b0;
        e_wa    = r_e;
        e_wd    = '{slot: r_i, state: ST_QUEUED};
        e_ra    = i_s_tdata[EL_W-1:0];
        unique case (r_state)
            S_CLR: begin
                e_we = 1'b1;
                e_wa = r_clr;
                e_wd = '{slot: '0, state: ST_NEVER};
                n_clr = r_clr + EL_W'(1);
                if (r_clr == EL_W'(CAPACITY - 1)) begin
                    n_last  = '0;
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_OUT;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    n_el   = i_s_tdata[EL_W-1:0];
                    n_cost = i_s_tdata[EL_W +: COST_W];
                    n_top  = '0;
                    n_sts  = STS_OK;
                    unique case (i_s_tuser)
                        OP_UPDATE: n_state = S_UPD;
                        OP_REMOVE: begin
                            if (r_last == '0) begin
                                n_sts   = STS_EMPTY;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_RM1;
                            end
                        end
                        OP_DELETE: n_state = S_DL1;
                        OP_RESET: begin
                            n_clr   = '0;
                            n_state = S_CLR;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_UPD: begin
                n_e = r_el;
                n_c = r_cost;
                priority if (e_rd.state == ST_DONE) begin
                    n_sts   = STS_DONE;
                    n_state = S_OUT;
                end else if (e_rd.state == ST_QUEUED) begin
                    n_i     = e_rd.slot;
                    n_state = S_SU_RD;
                end else if (r_last == SLOT_W'(CAPACITY)) begin
                    n_sts   = STS_FULL;
                    n_state = S_OUT;
                end else begin
                    n_last  = r_last + SLOT_W'(1);
                    n_i     = r_last + SLOT_W'(1);
                    n_state = S_SU_RD;
                end
            end
            S_SU_RD: begin
                h_ra = r_i >> 1;
                n_state = (r_i <= SLOT_W'(1)) ? S_FIN : S_SU_CMP;
            end
            S_SU_CMP: begin
                if (outranks(r_order, r_c, h_rd.cost)) begin
                    h_we    = 1'b1;
                    h_wd    = h_rd;
                    e_we    = 1'b1;
                    e_wa    = h_rd.elem;
                    n_i     = r_i >> 1;
                    n_state = S_SU_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                h_we    = 1'b1;
                e_we    = 1'b1;
                n_state = S_OUT;
            end
            S_SD_RL: begin
                h_ra = w_l[SLOT_W-1:0];
                n_state = (w_l > {1'b0, r_last}) ? S_FIN : S_SD_RR;
            end
            S_SD_RR: begin
                n_lt    = h_rd;
                h_ra    = w_r;
                n_hasr  = (w_r <= r_last);
                n_state = S_SD_CMP;
            end
            S_SD_CMP: begin
                if (r_hasr && outranks(r_order, h_rd.cost, r_lt.cost)) begin
                    h_wd = h_rd;
                    n_i  = w_r;
                end else begin
                    h_wd = r_lt;
                    n_i  = w_l[SLOT_W-1:0];
                end
                e_wa = h_wd.elem;
                if (outranks(r_order, h_wd.cost, r_c)) begin
                    h_we    = 1'b1;
                    e_we    = 1'b1;
                    n_state = S_SD_RL;
                end else begin
                    n_i     = r_i;
                    n_state = S_FIN;
                end
            end
            S_RM1: begin
                n_top = h_rd.elem;
                e_we  = 1'b1;
                e_wa  = h_rd.elem;
                e_wd  = '{slot: '0, state: ST_DONE};
                h_ra  = r_last;
                if (r_last == SLOT_W'(1)) begin
                    n_last  = '0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_RM2;
                end
            end
            S_RM2: begin
                n_e     = h_rd.elem;
                n_c     = h_rd.cost;
                n_last  = r_last - SLOT_W'(1);
                n_i     = SLOT_W'(1);
                n_state = S_SD_RL;
            end
            S_DL1: begin
                h_ra = e_rd.slot;
                if (e_rd.state != ST_QUEUED || r_last == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_i     = e_rd.slot;
                    e_we    = 1'b1;
                    e_wa    = r_el;
                    e_wd    = '{slot: '0, state: ST_NEVER};
                    n_state = S_DL2;
                end
            end
            S_DL2: begin
                n_dc    = h_rd.cost;
                h_ra    = r_last;
                n_state = S_DL3;
            end
            S_DL3: begin
                n_last = r_last - SLOT_W'(1);
                n_e    = h_rd.elem;
                n_c    = h_rd.cost;
                if (r_i >= r_last || h_rd.elem == r_el) begin
                    n_state = S_OUT;
                end else if (outranks(r_order, r_dc, h_rd.cost)) begin
                    n_state = S_SD_RL;
                end else begin
                    n_state = S_SU_RD;
                end
            end
            S_OUT: begin
                if (!r_ov || i_m_tready) begin
                    n_ov    = 1'b1;
                    n_od    = {(r_last == '0), r_last, r_sts, r_top};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_init  <= 1'b1;
            r_clr   <= '0;
            r_last  <= '0;
            r_ov    <= 1'b0;
            r_order <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_clr   <= n_clr;
            r_last  <= n_last;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_e    <= n_e;
        r_c    <= n_c;
        r_el   <= n_el;
        r_cost <= n_cost;
        r_dc   <= n_dc;
        r_lt   <= n_lt;
        r_hasr <= n_hasr;
        r_top  <= n_top;
        r_sts  <= n_sts;
        r_od   <= n_od;
    end
endmodule

// File: rtl/ibhq_checker.sv
`timescale 1ns / 1ps
`include "indexed_binary_heap_queue_top_defines.svh"
module ibhq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);
    `IBHQ_ASSERT_NEXT(a_hold, o_m_tvalid && !i_m_tready, o_m_tvalid, "result word dropped")
    `IBHQ_ASSERT_NOW(a_empty, o_m_tvalid, o_m_tdata[23] == (o_m_tdata[22:12] == 11'd0), "empty flag mismatch")
    `IBHQ_ASSERT_NOW(a_pop0, o_m_tvalid && o_m_tdata[11:10] == 2'd1, o_m_tdata[9:0] == 10'd0 && o_m_tdata[23], "bad empty pop")
    `IBHQ_ASSERT_NOW(a_cnt, o_m_tvalid, o_m_tdata[22:12] <= 11'd1024, "count out of range")
endmodule

bind indexed_binary_heap_queue_top ibhq_checker u_ibhq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
);
